// ===== hw/rtl/bpme_pkg.sv =====
// ----------------------------------------------------------------------------
// bpme_pkg
// Shared types, request and status codes, register map and default sizes
// for the bin packing move engine.
// ----------------------------------------------------------------------------
package bpme_pkg;

	localparam int unsigned DEF_MAX_ITEMS   = 256;
	localparam int unsigned DEF_MAX_BINS    = 256;
	localparam int unsigned DEF_LENGTH_BITS = 16;

	localparam int unsigned ADDR_BITS = 4;

	localparam logic [1:0] RQ_START = 2'd0;
	localparam logic [1:0] RQ_LOAD  = 2'd1;
	localparam logic [1:0] RQ_PLACE = 2'd2;
	localparam logic [1:0] RQ_MOVE  = 2'd3;

	localparam logic [2:0] ST_MOVED  = 3'd0;
	localparam logic [2:0] ST_NEWBIN = 3'd1;
	localparam logic [2:0] ST_PLACED = 3'd2;
	localparam logic [2:0] ST_DONE   = 3'd3;
	localparam logic [2:0] ST_REJECT = 3'd4;

	localparam logic [1:0] DM_BEST  = 2'd0;
	localparam logic [1:0] DM_GIVEN = 2'd2;

	localparam logic SM_LARGEST = 1'b0;

	localparam logic [1:0] REG_CAP = 2'd0;
	localparam logic [1:0] REG_SRC = 2'd1;
	localparam logic [1:0] REG_DST = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  item_index;
		logic [15:0] item_length;
		logic [7:0]  target_bin;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] moved_item;
		logic [7:0] from_bin;
		logic [7:0] to_bin;
		logic [8:0] bins_in_use;
	} rsp_t;

	typedef struct packed {
		logic [15:0] bin_capacity;
		logic        source_mode;
		logic [1:0]  dest_mode;
	} cfg_t;

endpackage

// ===== hw/rtl/bpme_cfg.sv =====
// ----------------------------------------------------------------------------
// bpme_cfg
// Register file behind the configuration port: bin capacity, source mode
// and destination mode, with read back.
// ----------------------------------------------------------------------------
module bpme_cfg import bpme_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bin_capacity <= 16'hFFFF;
			cfg_q.source_mode  <= SM_LARGEST;
			cfg_q.dest_mode    <= DM_BEST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_CAP: cfg_q.bin_capacity <= pwdata[15:0];
				REG_SRC: cfg_q.source_mode  <= pwdata[0];
				REG_DST: cfg_q.dest_mode    <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CAP: prdata = {16'd0, cfg_q.bin_capacity};
			REG_SRC: prdata = {31'd0, cfg_q.source_mode};
			REG_DST: prdata = {30'd0, cfg_q.dest_mode};
			default: prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;
	assign cfg    = cfg_q;

endmodule

// ===== hw/rtl/bin_packing_move_engine_top.sv =====
// ----------------------------------------------------------------------------
// bin_packing_move_engine_top
// Bin packing engine: item lengths and bin numbers in one item memory,
// bin free space in a bin memory; requests are worked by a sequencer.
// ----------------------------------------------------------------------------
// One request is taken at a time and its result word leaves through an output
// register. A move first scans bins and then items for its source when the
// source is the largest item of the emptiest bin, then scans bins for a
// destination and items for others in the source bin, and when its source bin
// empties, shifts the bins above it down. Each memory has a single read port:
// every scan over bins or items reads one entry per cycle. There is no
// clearing pass.
module bin_packing_move_engine_top import bpme_pkg::*; #(
	parameter int unsigned MAX_ITEMS   = DEF_MAX_ITEMS,
	parameter int unsigned MAX_BINS    = DEF_MAX_BINS,
	parameter int unsigned LENGTH_BITS = DEF_LENGTH_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int unsigned IW    = $clog2(MAX_ITEMS);
	localparam int unsigned BW    = $clog2(MAX_BINS);
	localparam int unsigned TW    = $clog2(MAX_BINS + 1);
	localparam int unsigned LB    = LENGTH_BITS;
	localparam int unsigned WW    = LB + BW;
	localparam int unsigned NSCAN = (MAX_ITEMS > MAX_BINS) ? MAX_ITEMS : MAX_BINS;
	localparam int unsigned SW    = $clog2(NSCAN + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PLACE = 4'd1;
	localparam logic [3:0] S_BSCAN = 4'd2;
	localparam logic [3:0] S_ISCAN = 4'd3;
	localparam logic [3:0] S_SRC   = 4'd4;
	localparam logic [3:0] S_SFREE = 4'd5;
	localparam logic [3:0] S_DINIT = 4'd6;
	localparam logic [3:0] S_DSCAN = 4'd7;
	localparam logic [3:0] S_DEC   = 4'd8;
	localparam logic [3:0] S_DWR   = 4'd9;
	localparam logic [3:0] S_RMV   = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;

	function automatic rsp_t mk_rsp(input logic [2:0] st, input logic [31:0] it,
		input logic [31:0] fr, input logic [31:0] to, input logic [31:0] bts);
		rsp_t r;
		r.status      = st;
		r.moved_item  = it[7:0];
		r.from_bin    = fr[7:0];
		r.to_bin      = to[7:0];
		r.bins_in_use = bts[8:0];
		return r;
	endfunction

	cfg_t cfg;

	bpme_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// state and scan control
	logic [3:0]           state_q;
	logic [SW-1:0]        cnt_q;
	logic                 vldb_s1, vldi_s1;
	logic [BW-1:0]        bidx_s1;
	logic [IW-1:0]        iidx_s1;
	logic [TW-1:0]        bt_q;
	logic [BW-1:0]        cursor_q;
	logic [MAX_ITEMS-1:0] loaded_q, placed_q;
	logic [IW-1:0]        item_q;
	logic [LB-1:0]        len_q, sfree_q, minleft_q, dfree_q;
	logic [BW-1:0]        src_q, dest_q;
	logic [7:0]           target_q;
	logic                 found_q, others_q, removed_q;
	rsp_t                 pend_q, rsp_q;
	logic                 rsp_valid_q;

	// memories
	logic [WW-1:0] item_mem [MAX_ITEMS];
	logic [LB-1:0] free_mem [MAX_BINS];
	logic [WW-1:0] item_rd_q, item_wdata;
	logic [LB-1:0] free_rd_q, free_wdata;
	logic [IW-1:0] item_raddr, item_waddr;
	logic [BW-1:0] free_raddr, free_waddr;
	logic          item_we, free_we;

	always_ff @(posedge clk) begin
		if (item_we)
			item_mem[item_waddr] <= item_wdata;
		item_rd_q <= item_mem[item_raddr];
	end

	always_ff @(posedge clk) begin
		if (free_we)
			free_mem[free_waddr] <= free_wdata;
		free_rd_q <= free_mem[free_raddr];
	end

	// decoded values
	logic [31:0]   cap32, len32, idx32, bt32, cnt32, sh32, btm1;
	logic [LB-1:0] cap, len_in, ilen;
	logic [BW-1:0] ibin, cur_c, fin_to;
	logic [IW-1:0] req_idx;
	logic          idx_ok, accept, load_ok, place_ok, given_ok;
	logic          pl_over, pl_full, pl_rej, mv_rej;
	logic [BW-1:0] pl_to;
	logic [LB:0]   sum;
	logic [LB-1:0] sat;
	logic          issue_b, issue_i, scan_end;
	logic          nsrc, fits;
	logic [LB-1:0] left;

	assign cap32   = {16'd0, cfg.bin_capacity};
	assign len32   = {16'd0, req.item_length};
	assign idx32   = {24'd0, req.item_index};
	assign bt32    = 32'(bt_q);
	assign cnt32   = 32'(cnt_q);
	assign sh32    = 32'(src_q) + cnt32 + 32'd1;
	assign btm1    = bt32 - 32'd1;
	assign cap     = cap32[LB-1:0];
	assign len_in  = len32[LB-1:0];
	assign req_idx = idx32[IW-1:0];
	assign idx_ok  = idx32 < MAX_ITEMS;
	assign ilen    = item_rd_q[WW-1:BW];
	assign ibin    = item_rd_q[BW-1:0];
	assign cur_c   = (32'(cursor_q) >= bt32) ? btm1[BW-1:0] : cursor_q;

	assign accept   = req_valid && !req_stall;
	assign load_ok  = idx_ok && (len_in != '0) && (len_in <= cap) && !placed_q[req_idx];
	assign place_ok = (bt_q != '0) && idx_ok && loaded_q[req_idx] && !placed_q[req_idx];
	assign given_ok = (bt_q != '0) && idx_ok && placed_q[req_idx];

	assign pl_over = ilen > free_rd_q;
	assign pl_full = bt32 >= MAX_BINS;
	assign pl_rej  = (ilen > cap) || (pl_over && pl_full);
	assign pl_to   = pl_over ? bt32[BW-1:0] : cursor_q;

	assign sum    = {1'b0, sfree_q} + {1'b0, len_q};
	assign sat    = sum[LB] ? '1 : sum[LB-1:0];
	assign mv_rej = !found_q && ((len_q > cap) || (others_q && pl_full));
	assign fin_to = found_q ? ((removed_q && dest_q > src_q) ? dest_q - 1'b1 : dest_q)
		: bt32[BW-1:0];

	assign nsrc = bidx_s1 != src_q;
	assign fits = len_q <= free_rd_q;
	assign left = free_rd_q - len_q;

	always_comb begin
		issue_b = 1'b0;
		issue_i = 1'b0;
		case (state_q)
			S_BSCAN: issue_b = cnt32 < bt32;
			S_ISCAN: issue_i = cnt32 < MAX_ITEMS;
			S_DSCAN: begin
				issue_b = cnt32 < bt32;
				issue_i = cnt32 < MAX_ITEMS;
			end
			S_RMV: begin
				issue_b = sh32 < bt32;
				issue_i = cnt32 < MAX_ITEMS;
			end
			default: ;
		endcase
	end

	assign scan_end = !issue_b && !issue_i && !vldb_s1 && !vldi_s1;

	// memory ports
	always_comb begin
		item_raddr = cnt32[IW-1:0];
		free_raddr = cnt32[BW-1:0];
		item_we    = 1'b0;
		item_waddr = item_q;
		item_wdata = {len_q, fin_to};
		free_we    = 1'b0;
		free_waddr = src_q;
		free_wdata = sat;
		unique case (state_q)
			S_IDLE: begin
				item_raddr = req_idx;
				free_raddr = cur_c;
				if (accept && req.req_type == RQ_START) begin
					free_we    = 1'b1;
					free_waddr = '0;
					free_wdata = cap;
				end
				if (accept && req.req_type == RQ_LOAD && load_ok) begin
					item_we    = 1'b1;
					item_waddr = req_idx;
					item_wdata = {len_in, {BW{1'b0}}};
				end
			end
			S_PLACE: begin
				if (!pl_rej) begin
					item_we    = 1'b1;
					item_wdata = {ilen, pl_to};
					free_we    = 1'b1;
					free_waddr = pl_to;
					free_wdata = pl_over ? cap - ilen : free_rd_q - ilen;
				end
			end
			S_SFREE: free_raddr = src_q;
			S_DEC: free_we = !mv_rej;
			S_DWR: begin
				free_we    = found_q;
				free_waddr = dest_q;
				free_wdata = dfree_q - len_q;
			end
			S_RMV: begin
				free_raddr = sh32[BW-1:0];
				free_we    = vldb_s1;
				free_waddr = bidx_s1 - 1'b1;
				free_wdata = free_rd_q;
				item_we    = vldi_s1 && placed_q[iidx_s1] && (ibin > src_q);
				item_waddr = iidx_s1;
				item_wdata = {ilen, ibin - 1'b1};
			end
			S_FIN: begin
				item_we    = 1'b1;
				free_we    = !found_q;
				free_waddr = bt32[BW-1:0];
				free_wdata = cap - len_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			vldb_s1     <= 1'b0;
			vldi_s1     <= 1'b0;
			bidx_s1     <= '0;
			iidx_s1     <= '0;
			bt_q        <= '0;
			cursor_q    <= '0;
			loaded_q    <= '0;
			placed_q    <= '0;
			item_q      <= '0;
			len_q       <= '0;
			sfree_q     <= '0;
			minleft_q   <= '0;
			dfree_q     <= '0;
			src_q       <= '0;
			dest_q      <= '0;
			target_q    <= '0;
			found_q     <= 1'b0;
			others_q    <= 1'b0;
			removed_q   <= 1'b0;
			pend_q      <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			vldb_s1 <= issue_b;
			vldi_s1 <= issue_i;
			bidx_s1 <= free_raddr;
			iidx_s1 <= item_raddr;
			if (issue_b || issue_i)
				cnt_q <= SW'(cnt32 + 32'd1);
			if (rsp_valid_q && !rsp_stall && state_q != S_OUT)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q   <= req_idx;
						target_q <= req.target_bin;
						cnt_q    <= '0;
						unique case (req.req_type)
							RQ_START: begin
								placed_q <= '0;
								bt_q     <= TW'(1);
								cursor_q <= '0;
								pend_q   <= mk_rsp(ST_DONE, 32'd0, 32'd0, 32'd0, 32'd1);
								state_q  <= S_OUT;
							end
							RQ_LOAD: begin
								if (load_ok)
									loaded_q[req_idx] <= 1'b1;
								pend_q  <= mk_rsp(load_ok ? ST_DONE : ST_REJECT, 32'd0, 32'd0,
									32'd0, bt32);
								state_q <= S_OUT;
							end
							RQ_PLACE: begin
								pend_q <= mk_rsp(ST_REJECT, 32'd0, 32'd0, 32'd0, bt32);
								if (place_ok) begin
									cursor_q <= cur_c;
									state_q  <= S_PLACE;
								end else begin
									state_q  <= S_OUT;
								end
							end
							default: begin
								pend_q <= mk_rsp(ST_REJECT, 32'd0, 32'd0, 32'd0, bt32);
								if (bt_q != '0 && cfg.source_mode == SM_LARGEST) begin
									src_q   <= '0;
									sfree_q <= '0;
									state_q <= S_BSCAN;
								end else if (cfg.source_mode != SM_LARGEST && given_ok) begin
									state_q <= S_SRC;
								end else begin
									state_q <= S_OUT;
								end
							end
						endcase
					end
				end
				S_PLACE: begin
					state_q <= S_OUT;
					if (!pl_rej) begin
						placed_q[item_q] <= 1'b1;
						if (pl_over) begin
							cursor_q <= pl_to;
							bt_q     <= TW'(bt32 + 32'd1);
							pend_q   <= mk_rsp(ST_PLACED, 32'(item_q), 32'd0, 32'(pl_to),
								bt32 + 32'd1);
						end else begin
							pend_q <= mk_rsp(ST_PLACED, 32'(item_q), 32'd0, 32'(pl_to), bt32);
						end
					end
				end
				S_BSCAN: begin
					if (vldb_s1 && (bidx_s1 == '0 || free_rd_q > sfree_q)) begin
						sfree_q <= free_rd_q;
						src_q   <= bidx_s1;
					end
					if (scan_end) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_ISCAN;
					end
				end
				S_ISCAN: begin
					if (vldi_s1 && placed_q[iidx_s1] && ibin == src_q
						&& (!found_q || ilen > len_q)) begin
						item_q  <= iidx_s1;
						len_q   <= ilen;
						found_q <= 1'b1;
					end
					if (scan_end)
						state_q <= found_q ? S_SFREE : S_OUT;
				end
				S_SRC: begin
					len_q   <= ilen;
					src_q   <= ibin;
					state_q <= S_SFREE;
				end
				S_SFREE: state_q <= S_DINIT;
				S_DINIT: begin
					sfree_q   <= free_rd_q;
					minleft_q <= free_rd_q;
					found_q   <= 1'b0;
					others_q  <= 1'b0;
					cnt_q     <= '0;
					state_q   <= S_DSCAN;
				end
				S_DSCAN: begin
					if (vldb_s1 && nsrc && fits) begin
						case (cfg.dest_mode)
							DM_BEST: begin
								if (left < minleft_q) begin
									minleft_q <= left;
									dest_q    <= bidx_s1;
									dfree_q   <= free_rd_q;
									found_q   <= 1'b1;
								end
							end
							DM_GIVEN: begin
								if (32'(bidx_s1) == 32'(target_q)) begin
									dest_q  <= bidx_s1;
									dfree_q <= free_rd_q;
									found_q <= 1'b1;
								end
							end
							default: begin
								if (!found_q) begin
									dest_q  <= bidx_s1;
									dfree_q <= free_rd_q;
									found_q <= 1'b1;
								end
							end
						endcase
					end
					if (vldi_s1 && placed_q[iidx_s1] && iidx_s1 != item_q && ibin == src_q)
						others_q <= 1'b1;
					if (scan_end)
						state_q <= S_DEC;
				end
				S_DEC: state_q <= mv_rej ? S_OUT : S_DWR;
				S_DWR: begin
					removed_q <= !others_q;
					cnt_q     <= '0;
					state_q   <= others_q ? S_FIN : S_RMV;
				end
				S_RMV: begin
					if (scan_end) begin
						bt_q <= TW'(btm1);
						if (cursor_q > src_q) begin
							if (btm1 != 32'd0 && 32'(cursor_q) - 32'd1 >= btm1)
								cursor_q <= BW'(btm1 - 32'd1);
							else
								cursor_q <= cursor_q - 1'b1;
						end else if (btm1 != 32'd0 && 32'(cursor_q) >= btm1) begin
							cursor_q <= BW'(btm1 - 32'd1);
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (found_q) begin
						pend_q <= mk_rsp(ST_MOVED, 32'(item_q), 32'(src_q), 32'(fin_to), bt32);
					end else begin
						bt_q   <= TW'(bt32 + 32'd1);
						pend_q <= mk_rsp(ST_NEWBIN, 32'(item_q), 32'(src_q), 32'(fin_to),
							bt32 + 32'd1);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= pend_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> req_stall)
		else $error("request taken while busy");
	a_bins_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(bt_q) <= MAX_BINS)
		else $error("bin count out of range");
	a_newbin_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_NEWBIN |-> rsp.to_bin == rsp.bins_in_use[7:0] - 8'd1)
		else $error("new bin is not the last bin");
	a_cursor_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && bt_q != '0 |-> 32'(cursor_q) < 32'(bt_q))
		else $error("fill cursor beyond open bins");
`endif

endmodule

// ===== test/bin_packing_move_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// bin_packing_move_engine_top_tb
// Self-checking bench for the bin packing move engine. A shadow model of
// item lengths, item bins and bin free space predicts every result word,
// and the bench compares it with the block's output. The stimulus is a
// directed opening, then phases of random start, load, place and move requests
// under several register settings. Both sides idle and stall in bursts.
// ----------------------------------------------------------------------------
module bin_packing_move_engine_top_tb import bpme_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 4000000;

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 0;
	rsp_t rsp;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bin_packing_move_engine_top dut (.*);

	always #6 clk = ~clk;

	// shadow state
	int item_len[256];
	int item_bin[256];
	int bin_free[256];
	bit item_loaded[256];
	bit item_placed[256];
	int bin_count, fill_bin;
	int cap_r = 65535;
	bit smode_r = 0;
	logic [1:0] dmode_r = DM_BEST;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int fails = 0;
	int cycles = 0;
	bit calm = 0;
	bit req_fired = 0;
	int gap = 0, stall_left = 0;
	int hold_asks = 0, hold_seen = 0, hold_left = 0;

	function automatic rsp_t mk(logic [2:0] st, int it, int fr, int dst);
		rsp_t o;
		o.status = st;
		o.moved_item = it[7:0];
		o.from_bin = fr[7:0];
		o.to_bin = dst[7:0];
		o.bins_in_use = bin_count[8:0];
		return o;
	endfunction

	function automatic void drop_bin(int b);
		for (int i = b; i + 1 < bin_count; i++)
			bin_free[i] = bin_free[i + 1];
		for (int i = 0; i < 256; i++)
			if (item_placed[i] && item_bin[i] > b)
				item_bin[i]--;
		bin_count--;
		if (fill_bin > b)
			fill_bin--;
		if (bin_count > 0 && fill_bin >= bin_count)
			fill_bin = bin_count - 1;
	endfunction

	function automatic rsp_t move_step(req_t r);
		int it = 0, src, len, sfree, dest = 0, minleft, dst, b, f;
		bit found = 0, others = 0, removed;
		if (bin_count == 0)
			return mk(ST_REJECT, 0, 0, 0);
		if (smode_r == SM_LARGEST) begin
			b = 0;
			for (int i = 1; i < bin_count; i++)
				if (bin_free[i] > bin_free[b])
					b = i;
			for (int i = 0; i < 256; i++)
				if (item_placed[i] && item_bin[i] == b && (!found || item_len[i] > item_len[it])) begin
					it = i;
					found = 1;
				end
		end else if (item_placed[r.item_index]) begin
			it = r.item_index;
			found = 1;
		end
		if (!found)
			return mk(ST_REJECT, 0, 0, 0);
		src = item_bin[it];
		len = item_len[it];
		sfree = bin_free[src];
		found = 0;
		if (dmode_r == DM_BEST) begin
			minleft = sfree;
			for (int i = 0; i < bin_count; i++)
				if (i != src && len <= bin_free[i] && bin_free[i] - len < minleft) begin
					minleft = bin_free[i] - len;
					dest = i;
					found = 1;
				end
		end else if (dmode_r == DM_GIVEN) begin
			if (r.target_bin < bin_count && r.target_bin != src && bin_free[r.target_bin] >= len) begin
				dest = r.target_bin;
				found = 1;
			end
		end else begin
			for (int i = 0; i < bin_count && !found; i++)
				if (i != src && bin_free[i] >= len) begin
					dest = i;
					found = 1;
				end
		end
		for (int i = 0; i < 256; i++)
			if (item_placed[i] && i != it && item_bin[i] == src)
				others = 1;
		if (!found && (len > cap_r || (others && bin_count >= 256)))
			return mk(ST_REJECT, 0, 0, 0);
		f = sfree + len;
		bin_free[src] = f > 65535 ? 65535 : f;
		if (found)
			bin_free[dest] -= len;
		removed = !others;
		if (removed)
			drop_bin(src);
		if (found) begin
			dst = (removed && dest > src) ? dest - 1 : dest;
		end else begin
			dst = bin_count;
			bin_free[dst] = cap_r - len;
			bin_count++;
		end
		item_bin[it] = dst;
		return mk(found ? ST_MOVED : ST_NEWBIN, it, src, dst);
	endfunction

	function automatic rsp_t pack_step(req_t r);
		int len;
		int ix = r.item_index;
		case (r.req_type)
			RQ_START: begin
				for (int i = 0; i < 256; i++)
					item_placed[i] = 0;
				bin_count = 1;
				bin_free[0] = cap_r;
				fill_bin = 0;
				return mk(ST_DONE, 0, 0, 0);
			end
			RQ_LOAD: begin
				len = r.item_length;
				if (len == 0 || len > cap_r || item_placed[ix])
					return mk(ST_REJECT, 0, 0, 0);
				item_len[ix] = len;
				item_loaded[ix] = 1;
				return mk(ST_DONE, 0, 0, 0);
			end
			RQ_PLACE: begin
				if (bin_count == 0 || !item_loaded[ix] || item_placed[ix] || item_len[ix] > cap_r)
					return mk(ST_REJECT, 0, 0, 0);
				len = item_len[ix];
				if (fill_bin >= bin_count)
					fill_bin = bin_count - 1;
				if (len > bin_free[fill_bin]) begin
					if (bin_count >= 256)
						return mk(ST_REJECT, 0, 0, 0);
					fill_bin = bin_count;
					bin_free[fill_bin] = cap_r;
					bin_count++;
				end
				bin_free[fill_bin] -= len;
				item_bin[ix] = fill_bin;
				item_placed[ix] = 1;
				return mk(ST_PLACED, ix, 0, fill_bin);
			end
			default: return move_step(r);
		endcase
	endfunction

	// acceptance, prediction and checking
	always @(posedge clk) begin
		rsp_t e;
		rsp_t p;
		cycles <= cycles + 1;
		req_fired <= req_valid && !req_stall;
		if (req_valid && !req_stall) begin
			p = pack_step(req);
			expected_rsps = {expected_rsps, p};
		end
		if (rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected result word %h", rsp);
				fails++;
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, rsp.status);
					fails++;
				end
				if (rsp.moved_item !== e.moved_item) begin
					$error("moved_item: expected %0d, got %0d", e.moved_item, rsp.moved_item);
					fails++;
				end
				if (rsp.from_bin !== e.from_bin) begin
					$error("from_bin: expected %0d, got %0d", e.from_bin, rsp.from_bin);
					fails++;
				end
				if (rsp.to_bin !== e.to_bin) begin
					$error("to_bin: expected %0d, got %0d", e.to_bin, rsp.to_bin);
					fails++;
				end
				if (rsp.bins_in_use !== e.bins_in_use) begin
					$error("bins_in_use: expected %0d, got %0d", e.bins_in_use, rsp.bins_in_use);
					fails++;
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_fired)) begin
			if (gap > 0) begin
				gap--;
				req_valid <= 0;
			end else if (pending_reqs.size() != 0) begin
				if (!calm && $urandom_range(0, 7) == 0) begin
					gap = $urandom_range(1, 14) - 1;
					req_valid <= 0;
				end else begin
					req <= pending_reqs.pop_front();
					req_valid <= 1;
				end
			end else begin
				req_valid <= 0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			rsp_stall <= 1;
		end else begin
			rsp_stall <= 0;
		end
	end

	task automatic push(logic [1:0] t, int ix, int len, int tb);
		req_t r;
		r.req_type = t;
		r.item_index = ix[7:0];
		r.item_length = len[15:0];
		r.target_bin = tb[7:0];
		pending_reqs = {pending_reqs, r};
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, int val);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= ADDR_BITS'(4 * idx);
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_CAP: cap_r = val & 16'hFFFF;
			REG_SRC: smode_r = val[0];
			default: dmode_r = val[1:0];
		endcase
	endtask

	task automatic random_phase(int n);
		int k, ix, len;
		push(RQ_START, $urandom_range(0, 255), $urandom, $urandom_range(0, 255));
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			ix = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 23);
			len = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, cap_r);
			if (k < 3)
				push(RQ_START, ix, len, 0);
			else if (k < 33)
				push(RQ_LOAD, ix, len, 0);
			else if (k < 63)
				push(RQ_PLACE, ix, $urandom, $urandom_range(0, 255));
			else
				push(RQ_MOVE, ix, $urandom,
					($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7));
		end
	endtask

	task automatic set_regs(int cap, int sm, int dm);
		wait_idle();
		reg_write(REG_CAP, cap);
		reg_write(REG_SRC, sm);
		reg_write(REG_DST, dm);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// opening: empty engine, field extremes, overflow into new bins
		push(RQ_MOVE, 0, 0, 0);
		push(RQ_PLACE, 0, 0, 0);
		push(RQ_START, 0, 0, 0);
		push(RQ_MOVE, 0, 0, 0);
		push(RQ_LOAD, 0, 0, 0);
		push(RQ_LOAD, 0, 65535, 0);
		push(RQ_LOAD, 1, 1, 0);
		push(RQ_LOAD, 255, 16'h8000, 255);
		push(RQ_LOAD, 2, 16'h7FFF, 0);
		push(RQ_PLACE, 3, 0, 0);
		push(RQ_PLACE, 0, 0, 0);
		push(RQ_PLACE, 0, 0, 0);
		push(RQ_LOAD, 0, 5, 0);
		push(RQ_PLACE, 1, 0, 0);
		push(RQ_PLACE, 255, 0, 0);
		push(RQ_PLACE, 2, 0, 0);
		push(RQ_MOVE, 0, 0, 0);
		push(RQ_MOVE, 255, 0, 255);
		push(RQ_MOVE, 0, 0, 0);
		push(RQ_MOVE, 0, 0, 0);
		random_phase(50);
		set_regs(1, 0, 1);
		random_phase(40);
		set_regs(300, 1, 2);
		wait_idle();
		hold_asks++;
		random_phase(80);
		set_regs(65535, 0, 3);
		random_phase(70);
		set_regs(100, 1, 0);
		random_phase(80);
		set_regs(2000, 0, 2);
		random_phase(80);
		set_regs(500, 1, 1);
		random_phase(70);
		set_regs(200, 0, 0);
		calm = 1;
		random_phase(80);
		wait_idle();
		repeat (1500) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/bpme_pkg.sv
hw/rtl/bpme_cfg.sv
hw/rtl/bin_packing_move_engine_top.sv
test/bin_packing_move_engine_top_tb.sv
